[rtl/wah_pkg.sv]
// ----------------------------------------------------------------------------
// wah_pkg
// types and constants shared by the wah bitmap and/or logic
// ----------------------------------------------------------------------------
package wah_pkg;

    localparam int LITERAL_BITS = 31;

    localparam logic [29:0] LEN_MASK  = 30'h3fffffff;
    localparam logic [29:0] LIT_LEN   = 30'(LITERAL_BITS);
    localparam logic [31:0] LIT_MASK  = 32'((64'd1 << LITERAL_BITS) - 64'd1);
    localparam logic [1:0]  HEAD_ZERO = 2'b10;
    localparam logic [1:0]  HEAD_ONE  = 2'b11;

    localparam logic [1:0] ACT_PUSH_A = 2'd0;
    localparam logic [1:0] ACT_PUSH_B = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    localparam logic OP_AND = 1'b0;
    localparam logic OP_OR  = 1'b1;

    localparam int          PADDR_W       = 3;
    localparam logic        REG_OP_SELECT = 1'b0;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] word;
    } req_t;

    typedef struct packed {
        logic        emit_valid;
        logic [31:0] out_word;
        logic        need_a;
        logic        need_b;
        logic        run_overflow;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] a_word;
        logic        a_full;
        logic [31:0] b_word;
        logic        b_full;
        logic [29:0] ones_run;
        logic [29:0] zeros_run;
    } slots_t;

    typedef struct packed {
        logic [1:0]  n_emit;
        logic [31:0] word0;
        logic [31:0] word1;
        logic        ovf;
    } step_t;

endpackage

[rtl/wah_merge_step.sv]
// ----------------------------------------------------------------------------
// wah_merge_step
// one push or finish request against the operand slots and run counters
// ----------------------------------------------------------------------------
module wah_merge_step (
    input  logic            op_select,
    input  wah_pkg::req_t   req,
    input  wah_pkg::slots_t cur,
    output wah_pkg::slots_t nxt,
    output wah_pkg::step_t  step
);

    logic [31:0] a_w;
    logic [31:0] b_w;
    logic        a_f;
    logic        b_f;
    logic        do_merge;
    logic        finish;
    logic        fa;
    logic        fb;
    logic [29:0] ca;
    logic [29:0] cb;
    logic [31:0] fill_w;
    logic [31:0] lit_w;
    logic [29:0] flen;
    logic        fval;
    logic        keep;
    logic [31:0] kept_w;
    logic [31:0] num;
    logic        add_en;
    logic        add_val;
    logic [29:0] add_n;
    logic        lit_en;
    logic [31:0] lit_out;
    logic [30:0] sum;
    logic [29:0] sat;
    logic        run_any;
    logic [31:0] run_word;

    always_comb
    begin
        a_w = cur.a_word;
        a_f = cur.a_full;
        b_w = cur.b_word;
        b_f = cur.b_full;

        case (req.action)
            wah_pkg::ACT_PUSH_A:
            begin
                if (!a_f)
                begin
                    a_w = req.word;
                    a_f = 1'b1;
                end
            end
            wah_pkg::ACT_PUSH_B:
            begin
                if (!b_f)
                begin
                    b_w = req.word;
                    b_f = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        do_merge = (req.action == wah_pkg::ACT_PUSH_A || req.action == wah_pkg::ACT_PUSH_B)
                   && a_f && b_f;
        finish   = (req.action == wah_pkg::ACT_FINISH);

        fa     = a_w[31];
        fb     = b_w[31];
        ca     = a_w[29:0];
        cb     = b_w[29:0];
        fill_w = fa ? a_w : b_w;
        lit_w  = fa ? b_w : a_w;
        flen   = fill_w[29:0];
        fval   = fill_w[30];
        keep   = (flen > wah_pkg::LIT_LEN);
        kept_w = {fill_w[31:30], flen - wah_pkg::LIT_LEN};
        num    = (op_select == wah_pkg::OP_OR) ? (a_w | b_w) : (a_w & b_w);

        add_en  = 1'b0;
        add_val = 1'b0;
        add_n   = '0;
        lit_en  = 1'b0;
        lit_out = '0;

        if (do_merge)
        begin
            if (fa && fb)
            begin
                add_en  = 1'b1;
                add_val = (op_select == wah_pkg::OP_OR) ? (a_w[30] | b_w[30])
                                                        : (a_w[30] & b_w[30]);
                add_n   = (ca < cb) ? ca : cb;
                if (ca == cb)
                begin
                    a_f = 1'b0;
                    b_f = 1'b0;
                end
                else if (ca > cb)
                begin
                    a_w = {a_w[31:30], ca - cb};
                    b_f = 1'b0;
                end
                else
                begin
                    b_w = {b_w[31:30], cb - ca};
                    a_f = 1'b0;
                end
            end
            else if (fa || fb)
            begin
                // a zero fill decides for and, a one fill decides for or
                if ((op_select == wah_pkg::OP_OR) ? !fval : fval)
                begin
                    lit_en  = 1'b1;
                    lit_out = lit_w;
                end
                else
                begin
                    add_en  = 1'b1;
                    add_val = fval;
                    add_n   = wah_pkg::LIT_LEN;
                end
                if (fa)
                begin
                    a_w = kept_w;
                    a_f = keep;
                    b_f = 1'b0;
                end
                else
                begin
                    b_w = kept_w;
                    b_f = keep;
                    a_f = 1'b0;
                end
            end
            else
            begin
                if (num == 32'd0)
                begin
                    add_en  = 1'b1;
                    add_val = 1'b0;
                    add_n   = wah_pkg::LIT_LEN;
                end
                else if (num == wah_pkg::LIT_MASK)
                begin
                    add_en  = 1'b1;
                    add_val = 1'b1;
                    add_n   = wah_pkg::LIT_LEN;
                end
                else
                begin
                    lit_en  = 1'b1;
                    lit_out = num;
                end
                a_f = 1'b0;
                b_f = 1'b0;
            end
        end

        if (finish)
        begin
            a_f = 1'b0;
            b_f = 1'b0;
        end
        if (!a_f)
        begin
            a_w = '0;
        end
        if (!b_f)
        begin
            b_w = '0;
        end

        nxt.a_word    = a_w;
        nxt.a_full    = a_f;
        nxt.b_word    = b_w;
        nxt.b_full    = b_f;
        nxt.ones_run  = cur.ones_run;
        nxt.zeros_run = cur.zeros_run;

        step.n_emit = 2'd0;
        step.word0  = '0;
        step.word1  = '0;
        step.ovf    = 1'b0;

        run_any  = (cur.ones_run != '0) || (cur.zeros_run != '0);
        run_word = (cur.ones_run != '0) ? {wah_pkg::HEAD_ONE, cur.ones_run}
                                        : {wah_pkg::HEAD_ZERO, cur.zeros_run};

        sum = {1'b0, add_val ? cur.ones_run : cur.zeros_run} + {1'b0, add_n};
        sat = sum[30] ? wah_pkg::LEN_MASK : sum[29:0];

        if (add_en)
        begin
            step.ovf = sum[30];
            if (add_val)
            begin
                nxt.ones_run  = sat;
                nxt.zeros_run = '0;
                if (cur.zeros_run != '0)
                begin
                    step.n_emit = 2'd1;
                    step.word0  = {wah_pkg::HEAD_ZERO, cur.zeros_run};
                end
            end
            else
            begin
                nxt.zeros_run = sat;
                nxt.ones_run  = '0;
                if (cur.ones_run != '0)
                begin
                    step.n_emit = 2'd1;
                    step.word0  = {wah_pkg::HEAD_ONE, cur.ones_run};
                end
            end
        end
        else if (lit_en || finish)
        begin
            nxt.ones_run  = '0;
            nxt.zeros_run = '0;
            if (run_any)
            begin
                step.n_emit = lit_en ? 2'd2 : 2'd1;
                step.word0  = run_word;
                step.word1  = lit_out;
            end
            else if (lit_en)
            begin
                step.n_emit = 2'd1;
                step.word0  = lit_out;
            end
        end
    end

endmodule

[rtl/wah_rsp_queue.sv]
// ----------------------------------------------------------------------------
// wah_rsp_queue
// small result queue, takes one or two results a cycle and gives one unless rd_stall holds it
// ----------------------------------------------------------------------------
module wah_rsp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic          wr_two,
    input  wah_pkg::rsp_t wr_data0,
    input  wah_pkg::rsp_t wr_data1,
    output logic          almost_full,
    output logic          rd_valid,
    input  logic          rd_stall,
    output wah_pkg::rsp_t rd_data
);

    wah_pkg::rsp_t                 entry_reg [wah_pkg::RQ_DEPTH];
    logic [wah_pkg::RQ_AW-1:0]     wr_ptr_reg;
    logic [wah_pkg::RQ_AW-1:0]     wr_ptr_next;
    logic [wah_pkg::RQ_AW-1:0]     wr_ptr_inc;
    logic [wah_pkg::RQ_AW-1:0]     rd_ptr_reg;
    logic [wah_pkg::RQ_AW-1:0]     rd_ptr_next;
    logic [wah_pkg::RQ_CW-1:0]     count_reg;
    logic [wah_pkg::RQ_CW-1:0]     count_next;
    logic [wah_pkg::RQ_CW-1:0]     n_wr;
    logic                          pop;

    assign rd_valid    = (count_reg != '0);
    assign rd_data     = entry_reg[rd_ptr_reg];
    assign almost_full = (count_reg > wah_pkg::RQ_CW'(wah_pkg::RQ_DEPTH - 2));
    assign pop         = rd_valid && !rd_stall;
    assign wr_ptr_inc  = wr_ptr_reg + wah_pkg::RQ_AW'(1);

    always_comb
    begin
        n_wr        = wr_en ? (wr_two ? wah_pkg::RQ_CW'(2) : wah_pkg::RQ_CW'(1)) : '0;
        count_next  = count_reg + n_wr - (pop ? wah_pkg::RQ_CW'(1) : '0);
        wr_ptr_next = wr_ptr_reg + n_wr[wah_pkg::RQ_AW-1:0];
        rd_ptr_next = rd_ptr_reg + (pop ? wah_pkg::RQ_AW'(1) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < wah_pkg::RQ_DEPTH; i++)
        begin
            if (wr_en && wr_ptr_reg == wah_pkg::RQ_AW'(i))
            begin
                entry_reg[i] <= wr_data0;
            end
            else if (wr_en && wr_two && wr_ptr_inc == wah_pkg::RQ_AW'(i))
            begin
                entry_reg[i] <= wr_data1;
            end
        end
    end

endmodule

[rtl/wah_compressed_bitmap_logic.sv]
// ----------------------------------------------------------------------------
// wah_compressed_bitmap_logic
// and/or of two wah compressed bitmaps, one compressed word per request
// ----------------------------------------------------------------------------
// Each request pushes one word into operand slot a or b, or finishes the
// bitmap. The merge step runs in the cycle the request is taken and its
// one or two results enter a four-entry result queue, the first of them
// shown once earlier results are read. One request a cycle is taken for as
// long as each request yields a single result and the consumer keeps up;
// a request yielding two results (a run flush then a literal) fills the
// queue faster than it drains, and req_stall rises once the queue holds
// three or more results. op_select (0 and, 1 or) is written over the apb
// port at address 0 and must only change while the block is idle.
module wah_compressed_bitmap_logic (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  wah_pkg::req_t               req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output wah_pkg::rsp_t               rsp_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wah_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    wah_pkg::slots_t slots_reg;
    wah_pkg::slots_t slots_next;
    wah_pkg::step_t  step;
    wah_pkg::rsp_t   res0;
    wah_pkg::rsp_t   res1;
    logic            op_select_reg;
    logic            req_acc;
    logic            cfg_wr;

    assign req_acc = req_valid && !req_stall;
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (paddr[2] == wah_pkg::REG_OP_SELECT);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == wah_pkg::REG_OP_SELECT) ? {31'd0, op_select_reg} : '0;

    wah_merge_step u_step (
        .op_select (op_select_reg),
        .req       (req_data),
        .cur       (slots_reg),
        .nxt       (slots_next),
        .step      (step)
    );

    always_comb
    begin
        res0.emit_valid   = (step.n_emit != 2'd0);
        res0.out_word     = step.word0;
        res0.need_a       = !slots_next.a_full;
        res0.need_b       = !slots_next.b_full;
        res0.run_overflow = step.ovf;
        res0.last         = (step.n_emit != 2'd2);

        res1.emit_valid   = 1'b1;
        res1.out_word     = step.word1;
        res1.need_a       = !slots_next.a_full;
        res1.need_b       = !slots_next.b_full;
        res1.run_overflow = step.ovf;
        res1.last         = 1'b1;
    end

    wah_rsp_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (req_acc),
        .wr_two      (step.n_emit == 2'd2),
        .wr_data0    (res0),
        .wr_data1    (res1),
        .almost_full (req_stall),
        .rd_valid    (rsp_valid),
        .rd_stall    (rsp_stall),
        .rd_data     (rsp_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= '0;
            op_select_reg <= wah_pkg::OP_AND;
        end
        else
        begin
            if (req_acc)
            begin
                slots_reg <= slots_next;
            end
            if (cfg_wr)
            begin
                op_select_reg <= pwdata[0];
            end
        end
    end

`ifndef SYNTHESIS
    // a merge always frees at least one slot
    assert property (@(posedge clk) disable iff (!rst_n)
        !(slots_reg.a_full && slots_reg.b_full))
        else $error("both operand slots full");

    // only one run counter is ever pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(slots_reg.ones_run != '0 && slots_reg.zeros_run != '0))
        else $error("ones and zeros runs both pending");

    // the second result of a request follows straight after the first
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
        else $error("second result of a request missing");
`endif

endmodule
